// File: hw/rtl/vnh_pkg.sv
// ----------------------------------------------------------------------------
// Value noise height package
// Shared widths, constants and the octave split helper.
// ----------------------------------------------------------------------------
package vnh_pkg;

    localparam int OctaveCount = 5;
    localparam int ScaleMax    = 10;
    localparam int FracUnits   = 44;

    localparam logic [63:0] HashMulY = 64'd13258953287;
    localparam logic [63:0] HashMulA = 64'd15731;
    localparam logic [63:0] HashAddA = 64'd789221;
    localparam logic [63:0] HashAddB = 64'd1376312589;

    localparam logic [0:0] RegScaleX = 1'b0;
    localparam logic [0:0] RegScaleY = 1'b1;

    typedef struct packed {
        logic [31:0] lat;
        logic [9:0]  frac;
        logic [3:0]  bits;
    } t_axis;

    // Lattice coordinate and fraction of one axis at one octave.
    function automatic t_axis split_axis(input logic [31:0] c, input logic [3:0] oct,
                                         input logic [3:0] scale);
        t_axis r;
        logic [3:0] k;
        r = '0;
        if (oct >= scale) begin
            k = oct - scale;
            r.lat = c << k;
        end else begin
            k = scale - oct;
            r.lat = $unsigned($signed(c) >>> k);
            r.frac = c[9:0] & ((10'd1 << k) - 10'd1);
            r.bits = k;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/vnh_corner.sv
// ----------------------------------------------------------------------------
// Value noise corner hash
// Pipelined 64-bit lattice hash, one point per enabled cycle, five stages.
// Only the low 44 bits of the first product and the low 31 bits after the
// shift and exclusive or can reach the 31-bit value, so wider bits are dropped.
// ----------------------------------------------------------------------------
module vnh_corner (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic [30:0] o_value
);
    import vnh_pkg::*;

    logic [43:0] r_h0;
    logic [30:0] r_h1;
    logic [30:0] r_sq;
    logic [30:0] r_h2;
    logic [30:0] r_poly;
    logic [30:0] r_h3;
    logic [30:0] r_val;
    logic [63:0] n_prod;
    logic [11:0] n_corr;
    logic [43:0] n_h0;

    always_comb begin
        n_prod = 64'(i_y) * 64'(HashMulY[31:0]);
        n_corr = 12'(i_y[11:0] * HashMulY[43:32]) - (i_y[31] ? HashMulY[11:0] : 12'd0);
        n_h0   = {{12{i_x[31]}}, i_x} + n_prod[43:0] + {n_corr, 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0   <= n_h0;
            r_h1   <= r_h0[30:0] ^ r_h0[43:13];
            r_sq   <= r_h1 * r_h1;
            r_h2   <= r_h1;
            r_poly <= r_sq * HashMulA[30:0] + HashAddA[30:0];
            r_h3   <= r_h2;
            r_val  <= r_h3 * r_poly + HashAddB[30:0];
        end
    end

    assign o_value = r_val;
endmodule

// File: hw/rtl/value_noise_height.sv
// ----------------------------------------------------------------------------
// Value noise height
// Five octave bilinear value noise terrain height from a coordinate pair.
// ----------------------------------------------------------------------------
// Latency is 11 register stages; the stage valid bits shift along with the data.
// Throughput is one word per cycle; the shared pipeline enable stalls all stages.
// Reset clears the stage valid bits and sets both scale exponents to six.
module value_noise_height (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // coord_x [31:0], coord_y [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // height [5:0], zero fill [7:6]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import vnh_pkg::*;

    localparam int Depth = 11;

    logic [3:0] r_scale_x;
    logic [3:0] r_scale_y;
    logic [Depth-1:0] r_vld;
    logic en;

    assign en = !r_vld[Depth-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x <= 4'd6;
            r_scale_y <= 4'd6;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    RegScaleX: r_scale_x <= i_cfg_data;
                    RegScaleY: r_scale_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (en) r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
        end
    end

    logic [3:0] sx, sy;
    assign sx = (r_scale_x > 4'(ScaleMax)) ? 4'(ScaleMax) : r_scale_x;
    assign sy = (r_scale_y > 4'(ScaleMax)) ? 4'(ScaleMax) : r_scale_y;

    // Stage 1: split both axes for every octave.
    t_axis r_ax [OctaveCount];
    t_axis r_ay [OctaveCount];
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < OctaveCount; i++) begin
                r_ax[i] <= split_axis(s_axis_tdata[31:0], 4'(i), sx);
                r_ay[i] <= split_axis(s_axis_tdata[63:32], 4'(i), sy);
            end
        end
    end

    // Stages 2..6: corner hashes; fractions delayed alongside.
    logic [30:0] v [OctaveCount][4];
    t_axis r_dx [OctaveCount][5];
    t_axis r_dy [OctaveCount][5];

    for (genvar g = 0; g < OctaveCount; g++) begin : g_oct
        for (genvar c = 0; c < 4; c++) begin : g_cor
            vnh_corner u_corner (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_x    (r_ax[g].lat + 32'(c % 2)),
                .i_y    (r_ay[g].lat + 32'(c / 2)),
                .o_value(v[g][c])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < OctaveCount; i++) begin
                r_dx[i][0] <= r_ax[i];
                r_dy[i][0] <= r_ay[i];
                for (int j = 1; j < 5; j++) begin
                    r_dx[i][j] <= r_dx[i][j-1];
                    r_dy[i][j] <= r_dy[i][j-1];
                end
            end
        end
    end

    // Stage 7: horizontal blend. Units 2^-(24+kx), at most 41 bits.
    logic [41:0] r_top [OctaveCount];
    logic [41:0] r_bot [OctaveCount];
    t_axis r_ey [OctaveCount];
    logic [3:0] r_kx [OctaveCount];
    // Stage 8: vertical blend, at most 51 bits.
    logic [51:0] r_mix [OctaveCount];
    logic [4:0] r_sh [OctaveCount];
    // Stage 9: shifted terms. Stage 10: sum. Stage 11: output.
    logic [51:0] r_term [OctaveCount];
    logic [51:0] r_sum;
    logic [51:0] n_sum;
    logic [5:0] r_height;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < OctaveCount; i++) begin
            n_sum = n_sum + r_term[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < OctaveCount; i++) begin
                r_top[i] <= 42'(v[i][0]) * 42'((11'd1 << r_dx[i][4].bits) - 11'(r_dx[i][4].frac))
                          + 42'(v[i][1]) * 42'(r_dx[i][4].frac);
                r_bot[i] <= 42'(v[i][2]) * 42'((11'd1 << r_dx[i][4].bits) - 11'(r_dx[i][4].frac))
                          + 42'(v[i][3]) * 42'(r_dx[i][4].frac);
                r_ey[i] <= r_dy[i][4];
                r_kx[i] <= r_dx[i][4].bits;
                r_mix[i] <= 52'(r_top[i]) * 52'((11'd1 << r_ey[i].bits) - 11'(r_ey[i].frac))
                          + 52'(r_bot[i]) * 52'(r_ey[i].frac);
                r_sh[i] <= 5'(FracUnits - 24 - i) - {1'b0, r_kx[i]} - {1'b0, r_ey[i].bits};
                r_term[i] <= r_mix[i] << r_sh[i];
            end
            r_sum <= n_sum;
            r_height <= r_sum[FracUnits+7:FracUnits+2];
        end
    end

    assign m_axis_tvalid = r_vld[Depth-1];
    assign m_axis_tdata = {2'b00, r_height};
endmodule
